### design/ncc_pkg.sv
`default_nettype none
package ncc_pkg;

  localparam int MaxBeadsDef  = 256;
  localparam int MaxPairsDef  = 1024;
  localparam int PairSetsDef  = 4;
  localparam int CoordBitsDef = 20;

  localparam int InCoordW  = 20;
  localparam int BeadW     = 8;
  localparam int SetW      = 2;
  localparam int SlotW     = 10;
  localparam int NativeW   = 42;
  localparam int CountW    = 11;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 11;
  localparam int ActiveW   = 9;
  localparam logic [CountW-1:0] CountMax = 11'd2047;

  // operation codes
  typedef enum logic [1:0] {
    OP_BEAD  = 2'd0,
    OP_PAIR  = 2'd1,
    OP_COUNT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ACTIVE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LEN0   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LEN3   = 3'd4;

  // count job handed from front to back
  typedef struct packed {
    logic [SetW-1:0] set;
    logic            set_ok;
  } job_t;

endpackage
`default_nettype wire

### design/native_contact_counter_unit.sv
`default_nettype none
// Native contact counter. Bead and pair writes keep busy low. A count
// request on a list (its length saturated at MaxPairs) gives its result
// after the queue hand-over, a walk in which each pair needs one pair-store
// read and two coordinate-store reads on single read ports, the end-of-list
// test, the pipeline drain and the result register.
// busy is high from the cycle after the count is accepted until the result
// cycle, so no write can change the stores under a count; the next command
// can be accepted in the result cycle. The result sits on out_strobe for one
// cycle and the receiver cannot stall it, so it must be captured when shown.
module native_contact_counter_unit #(
  parameter int MaxBeads  = ncc_pkg::MaxBeadsDef,
  parameter int MaxPairs  = ncc_pkg::MaxPairsDef,
  parameter int PairSets  = ncc_pkg::PairSetsDef,
  parameter int CoordBits = ncc_pkg::CoordBitsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [1:0]                    in_operation,
  input  wire logic [ncc_pkg::BeadW-1:0]     in_bead_index,
  input  wire logic signed [ncc_pkg::InCoordW-1:0] in_coord_x,
  input  wire logic signed [ncc_pkg::InCoordW-1:0] in_coord_y,
  input  wire logic signed [ncc_pkg::InCoordW-1:0] in_coord_z,
  input  wire logic [ncc_pkg::SetW-1:0]      in_pair_set,
  input  wire logic [ncc_pkg::SlotW-1:0]     in_pair_slot,
  input  wire logic [ncc_pkg::BeadW-1:0]     in_pair_first,
  input  wire logic [ncc_pkg::BeadW-1:0]     in_pair_second,
  input  wire logic [ncc_pkg::NativeW-1:0]   in_native_dist_sq,
  input  wire logic                          cfg_we,
  input  wire logic [ncc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [ncc_pkg::CfgDataW-1:0]  cfg_data,
  output      logic                          out_strobe,
  output      logic [ncc_pkg::CountW-1:0]    out_contact_count
);
  import ncc_pkg::*;
  localparam int PairAw = $clog2(PairSets*MaxPairs);
  localparam int BeadAw = $clog2(MaxBeads);
  localparam int PairWd = 2*BeadW + NativeW;

  logic [ActiveW-1:0] active_r;
  logic [CountW-1:0]  len_r [4];
  logic [SetW-1:0]    len_sel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 9'd256;
      for (int k = 0; k < 4; k++) len_r[k] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_ACTIVE) begin
        active_r <= cfg_data[ActiveW-1:0];
      end else if (cfg_index >= REG_LEN0 && cfg_index <= REG_LEN3) begin
        len_r[SetW'(cfg_index - REG_LEN0)] <= cfg_data;
      end
    end
  end

  logic bead_we, pair_we, job_valid, job_take, back_busy;
  logic [BeadAw-1:0] bead_waddr, bead_raddr;
  logic [PairAw-1:0] pair_waddr, pair_raddr;
  job_t job;
  logic [PairWd-1:0] pair_rdata;
  logic [3*CoordBits-1:0] bead_rdata;

  ncc_front #(.MaxBeads(MaxBeads), .MaxPairs(MaxPairs), .PairSets(PairSets)) u_front (
    .clk, .rst_n, .start, .busy, .in_operation, .in_bead_index, .in_pair_set,
    .in_pair_slot, .bead_we, .bead_waddr, .pair_we, .pair_waddr,
    .job_valid, .job, .job_take, .back_busy
  );

  ncc_ram #(.Width(3*CoordBits), .Depth(MaxBeads)) u_bead_ram (
    .clk, .we(bead_we), .waddr(bead_waddr),
    .wdata({in_coord_x[CoordBits-1:0], in_coord_y[CoordBits-1:0],
            in_coord_z[CoordBits-1:0]}),
    .raddr(bead_raddr), .rdata(bead_rdata)
  );

  ncc_ram #(.Width(PairWd), .Depth(PairSets*MaxPairs)) u_pair_ram (
    .clk, .we(pair_we), .waddr(pair_waddr),
    .wdata({in_pair_first, in_pair_second, in_native_dist_sq}),
    .raddr(pair_raddr), .rdata(pair_rdata)
  );

  ncc_back #(.MaxBeads(MaxBeads), .MaxPairs(MaxPairs), .PairSets(PairSets),
             .CoordBits(CoordBits)) u_back (
    .clk, .rst_n, .job_valid, .job, .job_take, .back_busy, .active_beads(active_r),
    .list_len(len_r[len_sel]), .len_sel, .pair_raddr, .pair_rdata,
    .bead_raddr, .bead_rdata, .out_strobe, .out_contact_count
  );
endmodule
`default_nettype wire

### design/ncc_ram.sv
`default_nettype none
module ncc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/ncc_front.sv
`default_nettype none
// Front: decodes commands, does store writes, queues count jobs.
module ncc_front #(
  parameter int MaxBeads  = ncc_pkg::MaxBeadsDef,
  parameter int MaxPairs  = ncc_pkg::MaxPairsDef,
  parameter int PairSets  = ncc_pkg::PairSetsDef
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output      logic                       busy,
  input  wire logic [1:0]                 in_operation,
  input  wire logic [ncc_pkg::BeadW-1:0]  in_bead_index,
  input  wire logic [ncc_pkg::SetW-1:0]   in_pair_set,
  input  wire logic [ncc_pkg::SlotW-1:0]  in_pair_slot,
  output      logic                       bead_we,
  output      logic [$clog2(MaxBeads)-1:0] bead_waddr,
  output      logic                       pair_we,
  output      logic [$clog2(PairSets*MaxPairs)-1:0] pair_waddr,
  output      logic                       job_valid,
  output      ncc_pkg::job_t              job,
  input  wire logic                       job_take,
  input  wire logic                       back_busy
);
  import ncc_pkg::*;
  localparam int PairAw = $clog2(PairSets*MaxPairs);
  localparam int SlotAw = (MaxPairs > 1) ? $clog2(MaxPairs) : 1;

  logic acc;
  op_t  op;
  logic q_full_r, q_full_nxt;
  job_t q_r, q_nxt;

  assign acc = start && !busy;
  assign op  = op_t'(in_operation);
  // a queued count or one being walked holds further commands off, so the
  // stores stay as they were when the count was accepted
  assign busy      = q_full_r || back_busy;
  assign job_valid = q_full_r;
  assign job       = q_r;

  // store write decode
  always_comb begin
    bead_we    = acc && (op == OP_BEAD) && (32'(in_bead_index) < MaxBeads);
    bead_waddr = $clog2(MaxBeads)'(in_bead_index);
    pair_we    = acc && (op == OP_PAIR) && (32'(in_pair_set) < PairSets)
                 && (32'(in_pair_slot) < MaxPairs);
    pair_waddr = PairAw'(32'(in_pair_set) * MaxPairs + 32'(SlotAw'(in_pair_slot)));
  end

  // job queue
  always_comb begin
    q_full_nxt = q_full_r;
    q_nxt      = q_r;
    if (job_take) begin
      q_full_nxt = 1'b0;
    end
    if (acc && op == OP_COUNT) begin
      q_full_nxt = 1'b1;
      q_nxt.set    = in_pair_set;
      q_nxt.set_ok = 32'(in_pair_set) < PairSets;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_full_r <= 1'b0;
    end else begin
      q_full_r <= q_full_nxt;
    end
    q_r <= q_nxt;
  end
endmodule
`default_nettype wire

### design/ncc_back.sv
`default_nettype none
// Back: walks one pair list through a read pipeline and counts contacts.
module ncc_back #(
  parameter int MaxBeads  = ncc_pkg::MaxBeadsDef,
  parameter int MaxPairs  = ncc_pkg::MaxPairsDef,
  parameter int PairSets  = ncc_pkg::PairSetsDef,
  parameter int CoordBits = ncc_pkg::CoordBitsDef
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        job_valid,
  input  wire ncc_pkg::job_t               job,
  output      logic                        job_take,
  output      logic                        back_busy,
  input  wire logic [ncc_pkg::ActiveW-1:0] active_beads,
  input  wire logic [ncc_pkg::CountW-1:0]  list_len,
  output      logic [ncc_pkg::SetW-1:0]    len_sel,
  output      logic [$clog2(PairSets*MaxPairs)-1:0] pair_raddr,
  input  wire logic [2*ncc_pkg::BeadW+ncc_pkg::NativeW-1:0] pair_rdata,
  output      logic [$clog2(MaxBeads)-1:0] bead_raddr,
  input  wire logic [3*CoordBits-1:0]      bead_rdata,
  output      logic                        out_strobe,
  output      logic [ncc_pkg::CountW-1:0]  out_contact_count
);
  import ncc_pkg::*;
  localparam int PairAw = $clog2(PairSets*MaxPairs);
  localparam int BeadAw = $clog2(MaxBeads);
  localparam int DiffW  = CoordBits + 1;
  localparam int SqW    = 2*DiffW;
  localparam int SumW   = SqW + 2;
  localparam int LhsW   = SumW + 5;
  localparam int RhsW   = NativeW + 6;
  localparam int CmpW   = (LhsW > RhsW) ? LhsW : RhsW;
  localparam int IdxW   = $clog2(MaxPairs + 1);

  // Per pair: pair read, bead i read, bead j read, diff, squares, sum,
  // compare, accumulate.
  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_DONE} state_t;
  state_t state_r;

  logic [IdxW-1:0] n_r, m_r;
  logic [1:0]      ph_r;        // phase within a pair: 0 pair, 1 pair word, 2 bead i, 3 bead j
  logic [SetW-1:0] set_r;
  logic [BeadW-1:0] pi_r, pj_r;
  logic [NativeW-1:0] nat_r;
  logic            skip_r;
  logic [3*CoordBits-1:0] ci_r;
  logic            jp_r;        // bead j word on rdata this cycle
  logic            e_v_r, s_v_r, c_v_r;
  logic signed [DiffW-1:0] dx_r, dy_r, dz_r;
  logic [NativeW-1:0] nat2_r, nat3_r;
  logic [SqW-1:0]  sx_r, sy_r, sz_r;
  logic [SumW-1:0] d2_r;
  logic            hit_r;
  logic [CountW-1:0] cnt_r;
  logic [3:0]      drain_r;

  logic [IdxW-1:0] nlim;
  logic [BeadW-1:0] rf, rs;
  logic bad;

  assign len_sel  = job.set;
  assign nlim     = (32'(list_len) > MaxPairs) ? IdxW'(MaxPairs) : IdxW'(list_len);
  assign job_take = (state_r == S_IDLE) && job_valid;
  assign back_busy = (state_r != S_IDLE);
  assign pair_raddr = PairAw'(32'(set_r) * MaxPairs + 32'(m_r));
  assign bead_raddr = (ph_r == 2'd2) ? BeadAw'(pi_r) : BeadAw'(pj_r);
  assign rf = pair_rdata[2*BeadW+NativeW-1 -: BeadW];
  assign rs = pair_rdata[BeadW+NativeW-1 -: BeadW];
  assign bad = (9'(rf) >= active_beads) || (9'(rs) >= active_beads)
               || (32'(rf) >= MaxBeads) || (32'(rs) >= MaxBeads);

  function automatic logic signed [DiffW-1:0] cdiff(input logic [CoordBits-1:0] a,
                                                   input logic [CoordBits-1:0] b);
    cdiff = DiffW'($signed(a)) - DiffW'($signed(b));
  endfunction

  function automatic logic [SqW-1:0] sq(input logic signed [DiffW-1:0] d);
    logic [DiffW-1:0] u;
    u  = d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
    sq = SqW'(u) * SqW'(u);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ph_r       <= 2'd0;
      jp_r       <= 1'b0;
      e_v_r      <= 1'b0;
      s_v_r      <= 1'b0;
      c_v_r      <= 1'b0;
      hit_r      <= 1'b0;
      cnt_r      <= '0;
      out_strobe <= 1'b0;
      out_contact_count <= '0;
    end else begin
      out_strobe <= (state_r == S_DONE);
      jp_r <= (state_r == S_WALK) && (ph_r == 2'd3);
      // difference stage: in phase 0 after a pair, bead j data is on rdata
      e_v_r <= jp_r && !skip_r;
      if (jp_r) begin
        dx_r <= cdiff(ci_r[3*CoordBits-1 -: CoordBits],
                      bead_rdata[3*CoordBits-1 -: CoordBits]);
        dy_r <= cdiff(ci_r[2*CoordBits-1 -: CoordBits],
                      bead_rdata[2*CoordBits-1 -: CoordBits]);
        dz_r <= cdiff(ci_r[CoordBits-1:0], bead_rdata[CoordBits-1:0]);
      end
      // square stage
      s_v_r <= e_v_r;
      sx_r <= sq(dx_r); sy_r <= sq(dy_r); sz_r <= sq(dz_r);
      nat2_r <= nat_r;
      // sum stage
      c_v_r <= s_v_r;
      d2_r  <= SumW'(sx_r) + SumW'(sy_r) + SumW'(sz_r);
      nat3_r <= nat2_r;
      // compare stage: 25*d2 <= 36*native by shifts and adds
      hit_r <= c_v_r && ((CmpW'(d2_r) << 4) + (CmpW'(d2_r) << 3) + CmpW'(d2_r)
                         <= (CmpW'(nat3_r) << 5) + (CmpW'(nat3_r) << 2));
      // accumulate
      if (hit_r && cnt_r != CountMax) begin
        cnt_r <= cnt_r + 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            set_r <= job.set;
            n_r   <= job.set_ok ? nlim : '0;
            m_r   <= '0;
            ph_r  <= 2'd0;
            cnt_r <= '0;
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          unique case (ph_r)
            2'd0: begin
              if (m_r == n_r) begin
                drain_r <= 4'd0;
                state_r <= S_DRAIN;
              end else begin
                ph_r <= 2'd1;
              end
            end
            2'd1: begin
              // pair word valid now
              pi_r   <= rf;
              pj_r   <= rs;
              nat_r  <= pair_rdata[NativeW-1:0];
              skip_r <= bad;
              ph_r   <= 2'd2;
            end
            2'd2: begin
              // bead i addressed
              ph_r <= 2'd3;
            end
            default: begin
              // bead i data valid; bead j addressed now, arrives next cycle
              ci_r <= bead_rdata;
              ph_r <= 2'd0;
              m_r  <= m_r + 1'b1;
            end
          endcase
        end
        S_DRAIN: begin
          drain_r <= drain_r + 1'b1;
          if (drain_r == 4'd6) begin
            state_r <= S_DONE;
          end
        end
        default: begin
          out_contact_count <= cnt_r;
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

### verif/ncc_contact_checker.sv
`default_nettype none
module ncc_contact_checker
  import ncc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [1:0]          in_operation,
  input  wire logic [BeadW-1:0]    in_bead_index,
  input  wire logic [InCoordW-1:0] in_coord_x,
  input  wire logic [InCoordW-1:0] in_coord_y,
  input  wire logic [InCoordW-1:0] in_coord_z,
  input  wire logic [SetW-1:0]     in_pair_set,
  input  wire logic [SlotW-1:0]    in_pair_slot,
  input  wire logic [BeadW-1:0]    in_pair_first,
  input  wire logic [BeadW-1:0]    in_pair_second,
  input  wire logic [NativeW-1:0]  in_native_dist_sq,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                out_strobe,
  input  wire logic [CountW-1:0]   out_contact_count,
  output int                       errors,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the block's stores and registers
  logic signed [InCoordW-1:0] bead_x [MaxBeadsDef];
  logic signed [InCoordW-1:0] bead_y [MaxBeadsDef];
  logic signed [InCoordW-1:0] bead_z [MaxBeadsDef];
  logic [BeadW-1:0]   pair_a   [PairSetsDef*MaxPairsDef];
  logic [BeadW-1:0]   pair_b   [PairSetsDef*MaxPairsDef];
  logic [NativeW-1:0] pair_nat [PairSetsDef*MaxPairsDef];
  logic [ActiveW-1:0]  active_beads;
  logic [CfgDataW-1:0] list_len [PairSetsDef];
  logic [CountW-1:0]   expected_counts [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report(input string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  function automatic longint sq_delta(input logic signed [InCoordW-1:0] a,
                                      input logic signed [InCoordW-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  // walks one list and counts pairs within 1.2x native distance
  function automatic logic [CountW-1:0] formed_contacts(input int s);
    int n;
    int k;
    int i;
    int j;
    longint unsigned d2;
    logic [CountW-1:0] nc;
    nc = '0;
    n = list_len[s];
    if (n > MaxPairsDef) n = MaxPairsDef;
    for (int m = 0; m < n; m++) begin
      k = s * MaxPairsDef + m;
      i = pair_a[k];
      j = pair_b[k];
      if (i >= active_beads || j >= active_beads) continue;
      d2 = sq_delta(bead_x[i], bead_x[j]) + sq_delta(bead_y[i], bead_y[j])
         + sq_delta(bead_z[i], bead_z[j]);
      if (25 * d2 <= 36 * longint'(pair_nat[k]) && nc != CountMax) nc++;
    end
    return nc;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      active_beads = ActiveW'(MaxBeadsDef);
      foreach (list_len[s]) list_len[s] = '0;
      expected_counts.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ACTIVE) active_beads = cfg_data[ActiveW-1:0];
        else if (cfg_index >= REG_LEN0 && cfg_index <= REG_LEN3)
          list_len[cfg_index - REG_LEN0] = cfg_data;
      end
      // accepted word
      if (start && !busy) begin
        case (op_t'(in_operation))
          OP_BEAD: begin
            bead_x[in_bead_index] = in_coord_x;
            bead_y[in_bead_index] = in_coord_y;
            bead_z[in_bead_index] = in_coord_z;
          end
          OP_PAIR: begin
            pair_a[in_pair_set * MaxPairsDef + in_pair_slot]   = in_pair_first;
            pair_b[in_pair_set * MaxPairsDef + in_pair_slot]   = in_pair_second;
            pair_nat[in_pair_set * MaxPairsDef + in_pair_slot] = in_native_dist_sq;
          end
          OP_COUNT: expected_counts.push_back(formed_contacts(in_pair_set));
          default: ;
        endcase
      end
      // result word
      if (out_strobe) begin
        if (expected_counts.size() == 0) begin
          report($sformatf("unexpected count %0d", out_contact_count));
        end else begin
          if (out_contact_count !== expected_counts[0])
            report($sformatf("contact_count %0d, expected %0d",
                             out_contact_count, expected_counts[0]));
          void'(expected_counts.pop_front());
        end
      end
    end
    pending = expected_counts.size();
  end

endmodule
`default_nettype wire

### verif/tb_native_contact_counter_unit.sv
`default_nettype none
module tb_native_contact_counter_unit;
  import ncc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1500000;
  localparam int CoordMax = 'h7FFFF;
  localparam int CoordMin = 'h80000;
  localparam longint NativeMax = (longint'(1) << NativeW) - 1;
  localparam int FillSlots = 32;
  localparam int Phases = 5;
  localparam int PhaseItems = 90;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]          in_operation = OP_NONE;
  logic [BeadW-1:0]    in_bead_index = '0;
  logic [InCoordW-1:0] in_coord_x = '0;
  logic [InCoordW-1:0] in_coord_y = '0;
  logic [InCoordW-1:0] in_coord_z = '0;
  logic [SetW-1:0]     in_pair_set = '0;
  logic [SlotW-1:0]    in_pair_slot = '0;
  logic [BeadW-1:0]    in_pair_first = '0;
  logic [BeadW-1:0]    in_pair_second = '0;
  logic [NativeW-1:0]  in_native_dist_sq = '0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = REG_ACTIVE;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                out_strobe;
  logic [CountW-1:0]   out_contact_count;
  int errors;
  int pending;
  int cycles = 0;
  int burst_left = 1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  native_contact_counter_unit uut (.*);

  ncc_contact_checker checker_i (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one word through the command port, with bursty idling
  task automatic put_word(input op_t op, input int bead, input int x, y, z,
                          input int set, input int slot, input int a, b,
                          input longint nat);
    int gap;
    in_operation <= op;
    in_bead_index <= BeadW'(bead);
    in_coord_x <= InCoordW'(x);
    in_coord_y <= InCoordW'(y);
    in_coord_z <= InCoordW'(z);
    in_pair_set <= SetW'(set);
    in_pair_slot <= SlotW'(slot);
    in_pair_first <= BeadW'(a);
    in_pair_second <= BeadW'(b);
    in_native_dist_sq <= NativeW'(nat);
    start <= 1'b1;
    do @(posedge clk); while (busy);
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic put_bead(input int bead, input int x, y, z);
    put_word(OP_BEAD, bead, x, y, z, $urandom, $urandom, $urandom, $urandom,
             {$urandom, $urandom});
  endtask

  task automatic put_pair(input int set, input int slot, input int a, b,
                          input longint nat);
    put_word(OP_PAIR, $urandom, $urandom, $urandom, $urandom, set, slot, a, b, nat);
  endtask

  task automatic put_count(input int set);
    put_word(OP_COUNT, $urandom, $urandom, $urandom, $urandom, set, $urandom,
             $urandom, $urandom, {$urandom, $urandom});
  endtask

  // drain: nothing outstanding and busy low, then a further idle wait for trailing writes
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= CfgIdxW'(idx);
    cfg_data <= CfgDataW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int rand_coord(input bit wide);
    return wide ? int'($urandom) : int'($urandom_range(0, 2047)) - 1024;
  endfunction

  function automatic longint rand_native(input bit wide);
    return wide ? longint'({$urandom, $urandom}) : longint'($urandom_range(0, 1 << 24));
  endfunction

  function automatic int rand_len();
    if ($urandom_range(0, 9) == 0) return 0;
    return $urandom_range(1, FillSlots);
  endfunction

  initial begin
    bit wide;
    int pick;
    int s;
    int sel;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every bead and the low slots of every list
    for (int b = 0; b < MaxBeadsDef; b++)
      put_bead(b, rand_coord(b[0]), rand_coord(b[0]), rand_coord(b[0]));
    for (int l = 0; l < PairSetsDef; l++)
      for (int k = 0; k < FillSlots; k++)
        put_pair(l, k, $urandom, $urandom, rand_native(k[0]));

    // directed: coordinate extremes, exact 1.2x boundary, zero native
    put_bead(0, CoordMax, CoordMax, CoordMax);
    put_bead(1, CoordMin, CoordMin, CoordMin);
    put_bead(2, 0, 0, 0);
    put_bead(3, 6, 0, 0);
    put_bead(255, CoordMin, CoordMax, 0);
    put_pair(0, 0, 0, 1, NativeMax);
    put_pair(0, 1, 0, 1, 0);
    put_pair(0, 2, 2, 2, 0);
    put_pair(0, 3, 2, 3, 25);
    put_pair(0, 4, 2, 3, 24);
    put_pair(0, 5, 0, 255, NativeMax);
    put_pair(0, 6, 255, 255, 0);
    put_word(OP_NONE, 7, CoordMax, CoordMin, 0, 1, 1, 1, 1, NativeMax);
    put_count(1);
    settle();
    write_reg(REG_LEN0, 7);
    put_count(0);
    settle();
    // no active beads, then one, then all but the last
    write_reg(REG_ACTIVE, 0);
    put_count(0);
    settle();
    write_reg(REG_ACTIVE, 1);
    put_count(0);
    settle();
    write_reg(REG_ACTIVE, 255);
    put_count(0);
    settle();
    write_reg(REG_ACTIVE, MaxBeadsDef);
    write_reg(REG_LEN0 + 1, 0);
    write_reg(REG_LEN0 + 2, FillSlots);
    write_reg(REG_LEN3, FillSlots);
    put_count(3);
    put_count(2);
    put_count(1);

    // random phases, each behind a fresh register setting
    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      pick = $urandom_range(0, 6);
      case (pick)
        0: write_reg(REG_ACTIVE, 0);
        1: write_reg(REG_ACTIVE, 2);
        2: write_reg(REG_ACTIVE, 511);
        3: write_reg(REG_ACTIVE, MaxBeadsDef);
        default: write_reg(REG_ACTIVE, $urandom_range(1, MaxBeadsDef));
      endcase
      for (int l = 0; l < PairSetsDef; l++) write_reg(REG_LEN0 + l, rand_len());
      for (int n = 0; n < PhaseItems; n++) begin
        sel = $urandom_range(0, 99);
        wide = $urandom_range(0, 1);
        s = $urandom_range(0, 3);
        if (sel < 35)
          put_bead($urandom, rand_coord(wide), rand_coord(wide), rand_coord(wide));
        else if (sel < 65)
          put_pair(s, $urandom_range(0, FillSlots - 1), $urandom, $urandom,
                   rand_native(wide));
        else if (sel < 95)
          put_count(s);
        else
          put_word(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, {$urandom, $urandom});
      end
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
design/ncc_pkg.sv
design/ncc_ram.sv
design/ncc_front.sv
design/ncc_back.sv
design/native_contact_counter_unit.sv
verif/ncc_contact_checker.sv
verif/tb_native_contact_counter_unit.sv
